// File: rtl/rgb_3x3_kernel_filter_top_assert.svh
// Assertion macros for the RGB 3x3 kernel filter.
// Used by rgb_3x3_kernel_filter_top; expects clk and arst_n in scope.
`ifndef RGB_3X3_KERNEL_FILTER_TOP_ASSERT_SVH
`define RGB_3X3_KERNEL_FILTER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define RKF_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("rkf: assertion failed");
`define RKF_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("rkf: forbidden condition seen");
`else
`define RKF_ASSERT(label, prop)
`define RKF_NEVER(label, cond)
`endif
`endif

// File: rtl/rkf_pkg.sv
// Shared types and constants of the RGB 3x3 kernel filter.
// No dependencies; imported by every rkf module.
package rkf_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;
	localparam int CNT_W          = 12;	// row/column counters
	localparam int DIM_W          = 11;	// width/height/end registers
	localparam int START_W        = 10;	// selection start registers
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 11;
	localparam int FIFO_DEPTH     = 8;
	// floor(x / 9) == (x * BOX_RECIP) >> BOX_SHIFT for x < 2300
	localparam logic [15:0] BOX_RECIP = 16'd7282;
	localparam int BOX_SHIFT      = 16;

	typedef enum logic [1:0] {
		KER_EDGE,
		KER_SHARPEN,
		KER_BOX,
		KER_GAUSS
	} kernel_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH,
		REG_IMAGE_HEIGHT,
		REG_SEL_ROW_START,
		REG_SEL_ROW_END,
		REG_SEL_COL_START,
		REG_SEL_COL_END,
		REG_KERNEL_SELECT
	} cfg_reg_t;

	typedef enum logic {
		OP_PIXEL,
		OP_FLUSH
	} op_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] in_red;
		logic [7:0] in_green;
		logic [7:0] in_blue;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic       frame_last;
	} out_item_t;

	// per-item control carried down the pipeline
	typedef struct packed {
		logic emit;
		logic sel;
		logic last;
	} ctl_t;

endpackage

// File: rtl/rkf_line_buf.sv
// Two line buffers (upper and middle rows) with registered read.
// Depends on rkf_pkg. Forwards the previous item's write to the same column while it is in flight.
module rkf_line_buf #(
	parameter int MAX_WIDTH = rkf_pkg::MAX_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rd_v,
	input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
	input  rkf_pkg::pixel_t              pix,
	output rkf_pkg::pixel_t              up_pix,
	output rkf_pkg::pixel_t              mid_pix,
	output rkf_pkg::pixel_t              pix_s1
);
	import rkf_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);

	pixel_t          upper_mem  [MAX_WIDTH];
	pixel_t          middle_mem [MAX_WIDTH];
	pixel_t          up_rd_s1, mid_rd_s1, fwd_up_s1, fwd_mid_s1, pix_hold_s1;
	logic [AW-1:0]   addr_s1;
	logic            v_s1, fwd_s1;

	// read port
	always_ff @(posedge clk) begin
		if (rd_v) begin
			up_rd_s1  <= upper_mem[rd_addr];
			mid_rd_s1 <= middle_mem[rd_addr];
		end
	end

	// stage payload and forwarding data
	always_ff @(posedge clk) begin
		if (rd_v) begin
			addr_s1     <= rd_addr;
			pix_hold_s1 <= pix;
			fwd_up_s1   <= mid_pix;
			fwd_mid_s1  <= pix_hold_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			fwd_s1 <= 1'b0;
		end else begin
			v_s1   <= rd_v;
			fwd_s1 <= rd_v && v_s1 && (rd_addr == addr_s1);
		end
	end

	// same column written last cycle: take the value in flight
	assign up_pix  = fwd_s1 ? fwd_up_s1  : up_rd_s1;
	assign mid_pix = fwd_s1 ? fwd_mid_s1 : mid_rd_s1;
	assign pix_s1  = pix_hold_s1;

	// write port: middle row moves up, new pixel becomes middle
	always_ff @(posedge clk) begin
		if (v_s1) begin
			upper_mem[addr_s1]  <= mid_pix;
			middle_mem[addr_s1] <= pix_hold_s1;
		end
	end

endmodule

// File: rtl/rkf_win_cell.sv
// One column of the 3x3 window: three pixels, shifted on from the neighbor.
// Depends on rkf_pkg.
module rkf_win_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  shift,
	input  rkf_pkg::pixel_t [2:0] col_in,
	output rkf_pkg::pixel_t [2:0] col_out
);
	import rkf_pkg::*;

	pixel_t [2:0] col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (shift) begin
			col_q <= col_in;
		end
	end

	assign col_out = col_q;

endmodule

// File: rtl/rkf_chan_filt.sv
// Kernel arithmetic for one color channel: sums registered, then kernel and clamp.
// Depends on rkf_pkg (kernel codes, box reciprocal).
module rkf_chan_filt (
	input  logic                  clk,
	input  logic                  en,
	input  logic [8:0][7:0]       win,	// index row*3 + col
	input  rkf_pkg::kernel_t      kernel,
	input  logic                  sel,
	output logic [7:0]            result
);
	import rkf_pkg::*;

	logic [7:0]  ctr_s3;
	logic [9:0]  edg_s3, cor_s3;
	logic [10:0] pos, neg;
	logic [11:0] box_sum;
	logic [27:0] box_prod;
	logic [12:0] gau_sum;
	logic [10:0] diff;
	logic [7:0]  filt;

	// neighbor sums
	always_ff @(posedge clk) begin
		if (en) begin
			ctr_s3 <= win[4];
			edg_s3 <= 10'(win[1]) + 10'(win[3]) + 10'(win[5]) + 10'(win[7]);
			cor_s3 <= 10'(win[0]) + 10'(win[2]) + 10'(win[6]) + 10'(win[8]);
		end
	end

	// kernel select and clamp
	always_comb begin
		pos      = '0;
		neg      = '0;
		diff     = '0;
		box_sum  = 12'(ctr_s3) + 12'(edg_s3) + 12'(cor_s3) + 12'd4;
		box_prod = 28'(box_sum) * 28'(BOX_RECIP);
		gau_sum  = {3'b0, ctr_s3, 2'b0} + {2'b0, edg_s3, 1'b0} + 13'(cor_s3) + 13'd8;
		case (kernel)
			KER_EDGE: begin
				pos = {ctr_s3, 3'b0};
				neg = 11'(edg_s3) + 11'(cor_s3);
			end
			KER_SHARPEN: begin
				pos = {1'b0, ctr_s3, 2'b0} + 11'(ctr_s3);
				neg = 11'(edg_s3);
			end
			default: ;
		endcase
		diff = pos - neg;
		case (kernel)
			KER_EDGE, KER_SHARPEN: begin
				if (pos <= neg) begin
					filt = 8'd0;
				end else if (diff > 11'd255) begin
					filt = 8'd255;
				end else begin
					filt = diff[7:0];
				end
			end
			KER_BOX: filt = box_prod[BOX_SHIFT+7:BOX_SHIFT];
			default: filt = gau_sum[11:4];
		endcase
	end

	assign result = sel ? filt : ctr_s3;

endmodule

// File: rtl/rkf_out_fifo.sv
// Output queue that decouples the filter pipeline from the result stall.
// Depends on rkf_pkg (result type).
module rkf_out_fifo #(
	parameter int DEPTH = rkf_pkg::FIFO_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  rkf_pkg::out_item_t           push_data,
	input  logic                         pop,
	output logic                         valid,
	output rkf_pkg::out_item_t           data,
	output logic [$clog2(DEPTH+1)-1:0]   count
);
	import rkf_pkg::*;

	localparam int PW = $clog2(DEPTH);

	out_item_t       mem [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [$clog2(DEPTH+1)-1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	// pointers wrap at the end of the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + $bits(cnt_q)'(push) - $bits(cnt_q)'(pop);
		end
	end

	assign valid = (cnt_q != '0);
	assign data  = mem[rd_ptr_q];
	assign count = cnt_q;

endmodule

// File: rtl/rgb_3x3_kernel_filter_top.sv
// RGB 3x3 kernel filter, top level: configuration, counters, window chain, queue.
// Depends on rkf_pkg, rkf_line_buf, rkf_win_cell, rkf_chan_filt, rkf_out_fifo.
// Takes one pixel or flush tick per clock and gives one result per clock in steady
// state while in_stall and out_stall stay low: the line buffers do one read and one
// write per cycle, and a three-stage pipeline (line read, window, neighbor sums; kernel
// and clamp combinational) feeds the output queue. The stream lags by one row plus one
// pixel, so the first W+1 pixels of a frame give no result and W+1 flush ticks after
// the last pixel drain the frame (frame_last marks its final pixel). A flush tick sent
// before the frame is complete is taken and has no effect. in_stall rises only when
// the eight-entry output queue plus the items in flight could not hold more; it does
// not follow out_stall combinationally. The user writes registers through the cfg port
// only while no frame is in progress, not enforced by the block; cfg_ready is always 1.
`include "rgb_3x3_kernel_filter_top_assert.svh"
module rgb_3x3_kernel_filter_top #(
	parameter int MAX_WIDTH  = rkf_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = rkf_pkg::MAX_HEIGHT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  rkf_pkg::in_item_t                 in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output rkf_pkg::out_item_t                out_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rkf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rkf_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import rkf_pkg::*;

	localparam int AW   = $clog2(MAX_WIDTH);
	localparam int DW   = CNT_W + 1;
	localparam int OCCW = $clog2(FIFO_DEPTH + 1) + 1;

	// configuration registers
	logic [DIM_W-1:0]   image_width_q, image_height_q, sel_row_end_q, sel_col_end_q;
	logic [START_W-1:0] sel_row_start_q, sel_col_start_q;
	kernel_t            kernel_q;

	// counters
	logic [CNT_W-1:0] in_row_q, in_col_q, out_row_q, out_col_q;
	logic [CNT_W-1:0] in_row_d, in_col_d, out_row_d, out_col_d;

	logic [DW-1:0] w_e, h_e;
	logic          in_acc, drain, enter;
	pixel_t        pix;
	logic [AW-1:0] idx;
	ctl_t          ctl_w, ctl_s1, ctl_s2, ctl_s3;
	logic          v_s1, v_s2, v_s3;

	pixel_t        up_pix, mid_pix, pix_s1;
	pixel_t [2:0]  col_in2, col0, col1, col2;
	logic [8:0][7:0] win_r, win_g, win_b;
	logic [7:0]    res_r, res_g, res_b;

	out_item_t     push_data;
	logic [$clog2(FIFO_DEPTH+1)-1:0] fifo_cnt;
	logic [OCCW-1:0] occ;

	// configuration writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q   <= DIM_W'(1024);
			image_height_q  <= DIM_W'(1024);
			sel_row_start_q <= '0;
			sel_row_end_q   <= DIM_W'(1024);
			sel_col_start_q <= '0;
			sel_col_end_q   <= DIM_W'(1024);
			kernel_q        <= KER_EDGE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_IMAGE_WIDTH:   image_width_q   <= cfg_data;
				REG_IMAGE_HEIGHT:  image_height_q  <= cfg_data;
				REG_SEL_ROW_START: sel_row_start_q <= cfg_data[START_W-1:0];
				REG_SEL_ROW_END:   sel_row_end_q   <= cfg_data;
				REG_SEL_COL_START: sel_col_start_q <= cfg_data[START_W-1:0];
				REG_SEL_COL_END:   sel_col_end_q   <= cfg_data;
				REG_KERNEL_SELECT: kernel_q        <= kernel_t'(cfg_data[1:0]);
				default: ;
			endcase
		end
	end

	// effective dimensions, saturated to 1..MAX
	always_comb begin
		if (image_width_q == '0) begin
			w_e = DW'(1);
		end else if (DW'(image_width_q) > DW'(MAX_WIDTH)) begin
			w_e = DW'(MAX_WIDTH);
		end else begin
			w_e = DW'(image_width_q);
		end
		if (image_height_q == '0) begin
			h_e = DW'(1);
		end else if (DW'(image_height_q) > DW'(MAX_HEIGHT)) begin
			h_e = DW'(MAX_HEIGHT);
		end else begin
			h_e = DW'(image_height_q);
		end
	end

	// transaction intake
	assign occ      = OCCW'(fifo_cnt) + OCCW'(v_s1) + OCCW'(v_s2) + OCCW'(v_s3);
	assign in_stall = (occ >= OCCW'(FIFO_DEPTH));
	assign in_acc   = in_valid && !in_stall;
	assign drain    = (DW'(in_row_q) >= h_e);
	assign enter    = in_acc && (drain || in_data.op == OP_PIXEL);
	assign pix      = drain ? '0 : {in_data.in_red, in_data.in_green, in_data.in_blue};
	assign idx      = (DW'(in_col_q) < DW'(MAX_WIDTH)) ? in_col_q[AW-1:0]
	                                                   : AW'(MAX_WIDTH - 1);

	// per-position decisions and counter update
	always_comb begin
		ctl_w.emit = (in_row_q >= CNT_W'(2)) ||
		             (in_row_q == CNT_W'(1) && in_col_q >= CNT_W'(1));
		ctl_w.sel  = (DW'(out_row_q) >= DW'(sel_row_start_q)) &&
		             (DW'(out_row_q) <  DW'(sel_row_end_q)) &&
		             (DW'(out_col_q) >= DW'(sel_col_start_q)) &&
		             (DW'(out_col_q) <  DW'(sel_col_end_q)) &&
		             (out_row_q >= CNT_W'(1)) && (DW'(out_row_q) + DW'(1) < h_e) &&
		             (out_col_q >= CNT_W'(1)) && (DW'(out_col_q) + DW'(1) < w_e);
		ctl_w.last = (DW'(out_row_q) + DW'(1) >= h_e) &&
		             (DW'(out_col_q) + DW'(1) >= w_e);

		in_row_d  = in_row_q;
		in_col_d  = in_col_q;
		out_row_d = out_row_q;
		out_col_d = out_col_q;
		if (DW'(in_col_q) + DW'(1) >= w_e) begin
			in_col_d = '0;
			in_row_d = in_row_q + 1'b1;
		end else begin
			in_col_d = in_col_q + 1'b1;
		end
		if (ctl_w.emit) begin
			if (ctl_w.last) begin
				in_row_d  = '0;
				in_col_d  = '0;
				out_row_d = '0;
				out_col_d = '0;
			end else if (DW'(out_col_q) + DW'(1) >= w_e) begin
				out_col_d = '0;
				out_row_d = out_row_q + 1'b1;
			end else begin
				out_col_d = out_col_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q  <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
		end else if (enter) begin
			in_row_q  <= in_row_d;
			in_col_q  <= in_col_d;
			out_row_q <= out_row_d;
			out_col_q <= out_col_d;
		end
	end

	// pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			v_s1 <= enter;
			v_s2 <= v_s1 && ctl_s1.emit;
			v_s3 <= v_s2;
			if (enter) ctl_s1 <= ctl_w;
			if (v_s1)  ctl_s2 <= ctl_s1;
			if (v_s2)  ctl_s3 <= ctl_s2;
		end
	end

	// line buffers
	rkf_line_buf #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_line_buf (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_v    (enter),
		.rd_addr (idx),
		.pix     (pix),
		.up_pix  (up_pix),
		.mid_pix (mid_pix),
		.pix_s1  (pix_s1)
	);

	// window: column 2 newest, row 0 top
	always_comb begin
		col_in2[0] = up_pix;
		col_in2[1] = mid_pix;
		col_in2[2] = pix_s1;
	end

	rkf_win_cell u_cell2 (.clk(clk), .arst_n(arst_n), .shift(v_s1),
		.col_in(col_in2), .col_out(col2));
	rkf_win_cell u_cell1 (.clk(clk), .arst_n(arst_n), .shift(v_s1),
		.col_in(col2), .col_out(col1));
	rkf_win_cell u_cell0 (.clk(clk), .arst_n(arst_n), .shift(v_s1),
		.col_in(col1), .col_out(col0));

	// channel slices of the window
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			win_r[r*3]   = col0[r].red;
			win_r[r*3+1] = col1[r].red;
			win_r[r*3+2] = col2[r].red;
			win_g[r*3]   = col0[r].green;
			win_g[r*3+1] = col1[r].green;
			win_g[r*3+2] = col2[r].green;
			win_b[r*3]   = col0[r].blue;
			win_b[r*3+1] = col1[r].blue;
			win_b[r*3+2] = col2[r].blue;
		end
	end

	rkf_chan_filt u_filt_r (.clk(clk), .en(v_s2), .win(win_r), .kernel(kernel_q),
		.sel(ctl_s3.sel), .result(res_r));
	rkf_chan_filt u_filt_g (.clk(clk), .en(v_s2), .win(win_g), .kernel(kernel_q),
		.sel(ctl_s3.sel), .result(res_g));
	rkf_chan_filt u_filt_b (.clk(clk), .en(v_s2), .win(win_b), .kernel(kernel_q),
		.sel(ctl_s3.sel), .result(res_b));

	// result queue
	always_comb begin
		push_data.out_red    = res_r;
		push_data.out_green  = res_g;
		push_data.out_blue   = res_b;
		push_data.frame_last = ctl_s3.last;
	end

	rkf_out_fifo #(
		.DEPTH(FIFO_DEPTH)
	) u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (v_s3),
		.push_data (push_data),
		.pop       (out_valid && !out_stall),
		.valid     (out_valid),
		.data      (out_data),
		.count     (fifo_cnt)
	);

	// queue plus items in flight never exceed its capacity
	`RKF_NEVER(a_no_overflow, occ > OCCW'(FIFO_DEPTH))
	// the last pixel of a frame returns all counters to the frame start
	`RKF_ASSERT(a_last_clears, (enter && ctl_w.emit && ctl_w.last) |=> (in_row_q == '0 && in_col_q == '0 && out_row_q == '0 && out_col_q == '0))
	// an early flush tick leaves the pipeline untouched
	`RKF_ASSERT(a_early_flush, (in_acc && !drain && in_data.op == OP_FLUSH) |=> !v_s1)
	// only emitting positions reach the kernel stage
	`RKF_ASSERT(a_emit_only, (v_s1 && !ctl_s1.emit) |=> !v_s2)

endmodule

// File: dv/rgb_3x3_kernel_filter_top_test.sv
// Self-checking testbench for the RGB 3x3 kernel filter top level.
// Depends on rkf_pkg and rgb_3x3_kernel_filter_top; a built-in predictor checks each output.
module rgb_3x3_kernel_filter_top_test;
	timeunit 1ns;
	timeprecision 1ps;
	import rkf_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int LINE_DEPTH     = 1024;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	in_item_t in_data;
	out_item_t out_data;
	logic cfg_valid, cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	rgb_3x3_kernel_filter_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor state
	logic [23:0] upper_row_buf [LINE_DEPTH];
	logic [23:0] middle_row_buf [LINE_DEPTH];
	logic [23:0] nbhd [3][3];	// [row][col], col 2 newest
	logic [11:0] in_row, in_col, out_row, out_col;
	logic [10:0] img_w, img_h, row_lo, row_hi, col_lo, col_hi;
	kernel_t kernel;

	out_item_t pending_pixels[$];
	int err_count = 0;
	int idle_cycles = 0;
	bit frame_closed;
	bit quiet = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic int sat_dim(logic [10:0] v);
		if (v < 1) return 1;
		if (v > LINE_DEPTH) return LINE_DEPTH;
		return v;
	endfunction

	// One channel of the selected kernel; sh picks the byte
	function automatic logic [7:0] kernel_chan(int sh);
		int c, e, k, v;
		c = (nbhd[1][1] >> sh) & 8'hff;
		e = ((nbhd[0][1] >> sh) & 8'hff) + ((nbhd[1][0] >> sh) & 8'hff)
			+ ((nbhd[1][2] >> sh) & 8'hff) + ((nbhd[2][1] >> sh) & 8'hff);
		k = ((nbhd[0][0] >> sh) & 8'hff) + ((nbhd[0][2] >> sh) & 8'hff)
			+ ((nbhd[2][0] >> sh) & 8'hff) + ((nbhd[2][2] >> sh) & 8'hff);
		case (kernel)
			KER_EDGE: v = 8 * c - e - k;
			KER_SHARPEN: v = 5 * c - e;
			KER_BOX: v = (c + e + k + 4) / 9;
			default: v = (4 * c + 2 * e + k + 8) / 16;
		endcase
		if (v < 0) v = 0;
		if (v > 255) v = 255;
		return v[7:0];
	endfunction

	// Advance the predicted filter by one accepted transaction
	task automatic predict_pixel(in_item_t it);
		int w, h, idx;
		logic [23:0] px;
		bit emit, sel, last;
		out_item_t o;
		w = sat_dim(img_w);
		h = sat_dim(img_h);
		if (in_row >= h) px = '0;
		else if (it.op == OP_PIXEL) px = {it.in_red, it.in_green, it.in_blue};
		else return;
		idx = (in_col < LINE_DEPTH) ? in_col : LINE_DEPTH - 1;
		for (int r = 0; r < 3; r++) begin
			nbhd[r][0] = nbhd[r][1];
			nbhd[r][1] = nbhd[r][2];
		end
		nbhd[0][2] = upper_row_buf[idx];
		nbhd[1][2] = middle_row_buf[idx];
		nbhd[2][2] = px;
		upper_row_buf[idx] = middle_row_buf[idx];
		middle_row_buf[idx] = px;
		emit = in_row >= 2 || (in_row == 1 && in_col >= 1);
		if (in_col + 1 >= w) begin
			in_col = 0;
			in_row = in_row + 1;
		end else begin
			in_col = in_col + 1;
		end
		if (!emit) return;
		sel = out_row >= row_lo && out_row < row_hi && out_col >= col_lo && out_col < col_hi
			&& out_row >= 1 && out_row + 1 < h && out_col >= 1 && out_col + 1 < w;
		last = out_row + 1 >= h && out_col + 1 >= w;
		if (sel) begin
			o.out_red = kernel_chan(16);
			o.out_green = kernel_chan(8);
			o.out_blue = kernel_chan(0);
		end else begin
			{o.out_red, o.out_green, o.out_blue} = nbhd[1][1];
		end
		o.frame_last = last;
		pending_pixels.push_back(o);
		if (last) begin
			in_row = 0; in_col = 0; out_row = 0; out_col = 0;
			frame_closed = 1;
		end else if (out_col + 1 >= w) begin
			out_col = 0;
			out_row = out_row + 1;
		end else begin
			out_col = out_col + 1;
		end
	endtask

	// Sender: random idle burst, then hold one transaction until accepted
	task automatic send_item(op_t op, logic [23:0] px);
		in_item_t it;
		int n;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			n = $urandom_range(1, 10);
			in_valid <= 0;
			repeat (n) @(posedge clk);
		end
		it.op = op;
		{it.in_red, it.in_green, it.in_blue} = px;
		in_valid <= 1;
		in_data <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_pixel(it);
	endtask

	task automatic settle();
		in_valid <= 0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t r, int v);
		cfg_valid <= 1;
		cfg_index <= r;
		cfg_data <= v[10:0];
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
		case (r)
			REG_IMAGE_WIDTH: img_w = v[10:0];
			REG_IMAGE_HEIGHT: img_h = v[10:0];
			REG_SEL_ROW_START: row_lo = {1'b0, v[9:0]};
			REG_SEL_ROW_END: row_hi = v[10:0];
			REG_SEL_COL_START: col_lo = {1'b0, v[9:0]};
			REG_SEL_COL_END: col_hi = v[10:0];
			default: kernel = kernel_t'(v[1:0]);
		endcase
	endtask

	task automatic setup(int w, int h, int rs, int re, int cs, int ce, kernel_t k);
		settle();
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
		write_reg(REG_SEL_ROW_START, rs);
		write_reg(REG_SEL_ROW_END, re);
		write_reg(REG_SEL_COL_START, cs);
		write_reg(REG_SEL_COL_END, ce);
		write_reg(REG_KERNEL_SELECT, k);
	endtask

	function automatic logic [7:0] rand_chan();
		case ($urandom_range(0, 3))
			0: return 8'h00;
			1: return 8'hff;
			default: return $urandom_range(0, 255);
		endcase
	endfunction

	// One whole frame: pixels with optional early flushes, then drain ticks
	task automatic run_frame(int noise);
		int npix;
		npix = sat_dim(img_w) * sat_dim(img_h);
		frame_closed = 0;
		for (int i = 0; i < npix; i++) begin
			if ($urandom_range(0, 99) < noise) send_item(OP_FLUSH, {rand_chan(), rand_chan(), rand_chan()});
			send_item(OP_PIXEL, {rand_chan(), rand_chan(), rand_chan()});
		end
		while (!frame_closed) begin
			if ($urandom_range(0, 99) < noise)
				send_item(OP_PIXEL, {rand_chan(), rand_chan(), rand_chan()});
			else
				send_item(OP_FLUSH, 24'h0);
		end
	endtask

	// Directed: every kernel on a 3x3 image with extreme pixels, early flush, drain pixel
	task automatic test_kernels();
		setup(3, 3, 0, 1024, 0, 1024, KER_EDGE);
		frame_closed = 0;
		send_item(OP_FLUSH, 24'hffffff);
		for (int i = 0; i < 9; i++) send_item(OP_PIXEL, (i == 4) ? 24'hffffff : 24'h000000);
		send_item(OP_PIXEL, 24'h123456);
		while (!frame_closed) send_item(OP_FLUSH, 24'h0);
		for (int k = 1; k < 4; k++) begin
			setup(3, 3, 1, 2, 1, 2, kernel_t'(k));
			run_frame(0);
		end
	endtask

	// Zero-size registers, wide and tall frames, minimal frame, empty selection
	task automatic test_dimensions();
		setup(0, 0, 1023, 1, 1023, 1, KER_SHARPEN);
		run_frame(20);
		setup(40, 3, 0, 2047, 0, 2047, KER_GAUSS);
		run_frame(0);
		setup(1, 40, 0, 1024, 0, 1024, KER_BOX);
		run_frame(0);
		setup(2, 2, 0, 1024, 0, 1024, KER_EDGE);
		run_frame(10);
	endtask

	// Random small frames with random selection and kernel
	task automatic test_random_frames(int frames);
		for (int f = 0; f < frames; f++) begin
			setup($urandom_range(1, 8), $urandom_range(1, 6), $urandom_range(0, 7),
				$urandom_range(1, 9), $urandom_range(0, 7), $urandom_range(1, 9),
				kernel_t'($urandom_range(0, 3)));
			run_frame($urandom_range(0, 1) ? 0 : 15);
			// hold off the sender until the output side has caught up
			if (f % 7 == 3) while (pending_pixels.size() != 0) @(posedge clk);
		end
	endtask

	// Output stall generator
	initial begin
		int n;
		out_stall <= 0;
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 10);
				out_stall <= 1;
				repeat (n) @(posedge clk);
				out_stall <= 0;
			end
		end
	end

	// Output checker
	always @(posedge clk) begin
		out_item_t exp_px;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_pixels.size() == 0) begin
				$error("unexpected output transaction");
				err_count++;
			end else begin
				exp_px = pending_pixels.pop_front();
				if (out_data.out_red !== exp_px.out_red) begin
					$error("out_red expected %0d actual %0d", exp_px.out_red, out_data.out_red);
					err_count++;
				end
				if (out_data.out_green !== exp_px.out_green) begin
					$error("out_green expected %0d actual %0d", exp_px.out_green, out_data.out_green);
					err_count++;
				end
				if (out_data.out_blue !== exp_px.out_blue) begin
					$error("out_blue expected %0d actual %0d", exp_px.out_blue, out_data.out_blue);
					err_count++;
				end
				if (out_data.frame_last !== exp_px.frame_last) begin
					$error("frame_last expected %0d actual %0d", exp_px.frame_last,
						out_data.frame_last);
					err_count++;
				end
			end
		end
	end

	// Watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("rgb_3x3_kernel_filter_top_test: errors");
			$finish;
		end
	end

	initial begin
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		cfg_valid = 0;
		cfg_index = '0;
		cfg_data = '0;
		for (int i = 0; i < LINE_DEPTH; i++) begin
			upper_row_buf[i] = '0;
			middle_row_buf[i] = '0;
		end
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++) nbhd[r][c] = '0;
		in_row = 0; in_col = 0; out_row = 0; out_col = 0;
		img_w = 1024; img_h = 1024; row_lo = 0; row_hi = 1024; col_lo = 0; col_hi = 1024;
		kernel = KER_EDGE;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_kernels();
		test_dimensions();
		test_random_frames(18);
		quiet = 1;
		test_random_frames(4);
		settle();
		repeat (20) @(posedge clk);
		if (err_count == 0)
			$display("rgb_3x3_kernel_filter_top_test: clean");
		else
			$display("rgb_3x3_kernel_filter_top_test: errors");
		$finish;
	end

endmodule
